### rtl/sfis_pkg.sv
// Shared types and constants for the sorted table fractional index search.
// No dependencies; every other file of the block but sfis_ram imports this package.
package sfis_pkg;

   // Table geometry and field widths
   localparam int TABLE_DEPTH   = 2048;
   localparam int VALUE_BITS    = 34;
   localparam int FRACTION_BITS = 16;
   localparam int INDEX_BITS    = 11;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   // Search bounds run from first-1 up to last+1, so carry a sign and a spare bit
   localparam int POS_BITS      = ADDR_BITS + 2;
   localparam int COUNT_BITS    = $clog2(FRACTION_BITS + 1);

   localparam logic [FRACTION_BITS-1:0] FRAC_MAX = {FRACTION_BITS{1'b1}};

   // Operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef logic signed [POS_BITS-1:0] pos_type;

   typedef enum logic [1:0] {
      STATUS_EXACT  = 2'd0,
      STATUS_INTERP = 2'd1,
      STATUS_BELOW  = 2'd2,
      STATUS_ABOVE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_READ_LO,
      ST_READ_HI,
      ST_PREP,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic                    opcode;
      logic [INDEX_BITS-1:0]   entry_index;
      logic [VALUE_BITS-1:0]   entry_value;
      logic [INDEX_BITS-1:0]   segment_first;
      logic [INDEX_BITS-1:0]   segment_last;
      logic [VALUE_BITS-1:0]   target;
   } req_word_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]    sample_index;
      logic [FRACTION_BITS-1:0] fraction;
      status_type               status;
   } rsp_word_type;

   // Handshake between the search sequencer and the serial divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

endpackage

### rtl/sfis_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sfis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Store on write, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sfis_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle into a shift register.
// Depends on sfis_pkg. Expects numerator below denominator.
module sfis_divider
   import sfis_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  div_ctrl_type             ctrl,
   input  logic [VALUE_BITS-1:0]    numerator,
   input  logic [VALUE_BITS-1:0]    denominator,
   output div_stat_type             stat,
   output logic [FRACTION_BITS-1:0] quotient
);

   logic [VALUE_BITS:0]      rem_ff, rem_in;
   logic [VALUE_BITS-1:0]    den_ff, den_in;
   logic [FRACTION_BITS-1:0] quot_ff, quot_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     done_ff, done_in;
   logic [VALUE_BITS:0]      shifted;
   logic [VALUE_BITS:0]      trial;
   logic                     take;

   // One restoring step: double the remainder and try the divisor
   always_comb begin
      shifted = {rem_ff[VALUE_BITS-1:0], 1'b0};
      trial   = shifted - {1'b0, den_ff};
      take    = shifted >= {1'b0, den_ff};
   end

   // Load on start, shift a quotient bit in while the count runs
   always_comb begin
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         rem_in   = {1'b0, numerator};
         den_in   = denominator;
         quot_in  = '0;
         count_in = COUNT_BITS'(FRACTION_BITS);
      end else if (count_ff != '0) begin
         rem_in   = take ? trial : shifted;
         quot_in  = {quot_ff[FRACTION_BITS-2:0], take};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == COUNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

### rtl/sorted_table_fractional_index_search.sv
// Top level of the sorted table fractional index search.
// Depends on sfis_pkg, sfis_ram and sfis_divider.
//
// A write word (opcode 0) stores one table entry in the cycle it is taken and
// leaves busy low, so words may follow every cycle; it gives no result. A
// search word (opcode 1) raises busy until its result has been formed: each
// binary search probe is an address state, then a registered RAM read and
// compare, at most twelve probes for the 2048-entry table; a last probe state
// finds the range closed, then ST_READ_LO and ST_READ_HI fetch both neighbours
// and ST_PREP tests them, then the bit-serial divider takes sixteen steps and
// raises done to hand over its quotient for an interpolated answer. An exact
// hit, a target outside the segment or a trivial fraction ends it earlier. The
// single RAM read port and the one-bit-a-cycle divider set how long busy stays
// high. The result shows on rsp_word for exactly one cycle with rsp_strobe
// high, in the first cycle that busy is low; the receiver cannot stall it and
// must take it then. Entries must be written before a search reads them.
module sorted_table_fractional_index_search
   import sfis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] tgt_ff, tgt_in;
   logic [ADDR_BITS-1:0]  first_ff, first_in;
   logic [ADDR_BITS-1:0]  last_ff, last_in;
   pos_type               head_ff, head_in;
   pos_type               tail_ff, tail_in;
   logic [ADDR_BITS-1:0]  mid_ff, mid_in;
   logic [VALUE_BITS-1:0] lo_ff, lo_in;
   logic [VALUE_BITS:0]   num_ff, num_in;
   logic [VALUE_BITS:0]   den_ff, den_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                     accept;
   logic                     wr_en;
   logic [ADDR_BITS-1:0]     rd_addr;
   logic [VALUE_BITS-1:0]    rd_data;
   logic [ADDR_BITS-1:0]     first_clamp;
   logic [ADDR_BITS-1:0]     last_clamp;
   logic [POS_BITS-1:0]      pos_sum;
   logic [ADDR_BITS-1:0]     mid;
   logic                     range_open;
   logic                     below;
   logic                     above;
   logic                     frac_zero;
   logic                     frac_sat;
   logic [INDEX_BITS-1:0]    tail_index;
   div_ctrl_type             div_ctrl;
   div_stat_type             div_stat;
   logic [FRACTION_BITS-1:0] div_quot;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign wr_en  = accept && (req_word.opcode == OP_WRITE) &&
                   (32'(req_word.entry_index) < 32'(TABLE_DEPTH));

   // Saturate segment bounds to the table
   assign first_clamp = (32'(req_word.segment_first) >= 32'(TABLE_DEPTH)) ?
                        ADDR_BITS'(TABLE_DEPTH - 1) : ADDR_BITS'(req_word.segment_first);
   assign last_clamp  = (32'(req_word.segment_last) >= 32'(TABLE_DEPTH)) ?
                        ADDR_BITS'(TABLE_DEPTH - 1) : ADDR_BITS'(req_word.segment_last);

   // Search decisions; both bounds are non-negative while the range is open
   always_comb begin
      pos_sum    = head_ff + tail_ff;
      mid        = pos_sum[ADDR_BITS:1];
      range_open = (head_ff <= tail_ff);
      below      = (tail_ff < $signed({2'b00, first_ff}));
      above      = (tail_ff >= $signed({2'b00, last_ff}));
      frac_zero  = num_ff[VALUE_BITS] || den_ff[VALUE_BITS] || (den_ff == '0);
      frac_sat   = (num_ff >= den_ff);
      tail_index = INDEX_BITS'(tail_ff[ADDR_BITS-1:0]);
   end

   sfis_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ADDR_BITS'(req_word.entry_index)),
      .wr_data(req_word.entry_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   sfis_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .numerator  (num_ff[VALUE_BITS-1:0]),
      .denominator(den_ff[VALUE_BITS-1:0]),
      .stat       (div_stat),
      .quotient   (div_quot)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.opcode == OP_SEARCH)) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (range_open) begin
               state_in = ST_COMPARE;
            end else if (below || above) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_LO;
            end
         end
         ST_COMPARE: begin
            state_in = (rd_data == tgt_ff) ? ST_IDLE : ST_PROBE;
         end
         ST_READ_LO: state_in = ST_READ_HI;
         ST_READ_HI: state_in = ST_PREP;
         ST_PREP: begin
            state_in = (frac_zero || frac_sat) ? ST_IDLE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result word
   always_comb begin
      tgt_in         = tgt_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      mid_in         = mid_ff;
      lo_in          = lo_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      rsp_strobe_in  = 1'b0;
      rsp_word_in    = rsp_word_ff;
      rd_addr        = mid;
      div_ctrl.start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Latch the search fields of any accepted word
            if (accept) begin
               tgt_in   = req_word.target;
               first_in = first_clamp;
               last_in  = last_clamp;
               head_in  = $signed({2'b00, first_clamp});
               tail_in  = $signed({2'b00, last_clamp});
            end
         end
         ST_PROBE: begin
            if (range_open) begin
               mid_in = mid;
            end else if (below) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{INDEX_BITS'(first_ff), '0, STATUS_BELOW};
            end else if (above) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{INDEX_BITS'(last_ff), '0, STATUS_ABOVE};
            end else begin
               // Fetch the lower neighbour
               rd_addr = tail_ff[ADDR_BITS-1:0];
            end
         end
         ST_COMPARE: begin
            if (rd_data < tgt_ff) begin
               head_in = $signed({2'b00, mid_ff}) + pos_type'(1);
            end else if (rd_data == tgt_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{INDEX_BITS'(mid_ff), '0, STATUS_EXACT};
            end else begin
               tail_in = $signed({2'b00, mid_ff}) - pos_type'(1);
            end
         end
         ST_READ_LO: begin
            // Hold the lower neighbour, fetch the upper one
            lo_in   = rd_data;
            num_in  = {1'b0, tgt_ff} - {1'b0, rd_data};
            rd_addr = tail_ff[ADDR_BITS-1:0] + 1'b1;
         end
         ST_READ_HI: begin
            den_in = {1'b0, rd_data} - {1'b0, lo_ff};
         end
         ST_PREP: begin
            if (frac_zero) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{tail_index, '0, STATUS_INTERP};
            end else if (frac_sat) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{tail_index, FRAC_MAX, STATUS_INTERP};
            end else begin
               div_ctrl.start = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{tail_index, div_quot, STATUS_INTERP};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      mid_ff      <= mid_in;
      lo_ff       <= lo_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

### rtl/sfis_checker.sv
// Port-level checks for the sorted table fractional index search, bound to the top.
// Depends on sfis_pkg and sorted_table_fractional_index_search.
module sfis_checker
   import sfis_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_strobe,
   input rsp_word_type rsp_word
);

   // A write word finishes at once and never yields a result
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.opcode == OP_WRITE)) |=> (!rsp_strobe && !busy))
      else $error("write word raised busy or a result");

   // A search word holds the block busy
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.opcode == OP_SEARCH)) |=> busy)
      else $error("search word did not raise busy");

   // A result follows the fall of busy and lasts one cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !$past(rsp_strobe)))
      else $error("result word without a finished search");

   // Only an interpolated answer carries a fraction
   a_fraction_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status != STATUS_INTERP)) |-> (rsp_word.fraction == '0))
      else $error("non-interpolated result with a fraction");

endmodule

bind sorted_table_fractional_index_search sfis_checker u_sfis_checker (.*);
